@@ hw/rtl/rpap_pkg.sv @@
// ----------------------------------------------------------------------------
// rpap_pkg: shared types and constants for the point rotation pipeline
// Coordinate and angle formats, angle reduction constants, CORDIC tables and
// the structs that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package rpap_pkg;

	// Field widths
	localparam int COORD_BITS   = 24;
	localparam int ANGLE_BITS   = 20;
	localparam int CORDIC_STEPS = 30;

	// Angle units are 1/256 degree
	localparam int FULL_TURN    = 92160;
	localparam int QUARTER_TURN = 23040;

	// Whole turns added so that every angle code becomes positive
	localparam int TURN_BIAS = ((1 << (ANGLE_BITS - 1)) + FULL_TURN - 1) / FULL_TURN;
	localparam int U_BITS    = $clog2((1 << (ANGLE_BITS - 1)) + TURN_BIAS * FULL_TURN);
	localparam int MAX_TURNS = ((1 << (ANGLE_BITS - 1)) - 1 + TURN_BIAS * FULL_TURN)
		/ FULL_TURN;
	localparam int R_BITS    = $clog2(FULL_TURN);
	localparam int REM_BITS  = $clog2(QUARTER_TURN);

	// rem * (pi/4 * 2^30) / 11520 = rem * ZQ_INT + floor(rem * ZQ_FRAC / 11520)
	// 11520 = 256 * 45; the divide by 45 uses a reciprocal that is exact here.
	localparam int ZQ_INT       = 73204;
	localparam int ZQ_FRAC      = 4777;
	localparam int ZQ_SHIFT     = 8;
	localparam int RECIP45      = 1491309;
	localparam int RECIP45_BITS = 21;
	localparam int RECIP_SHIFT  = 26;

	// CORDIC datapath (Q1.30 for x/y, Q2.30 radians for z)
	localparam int FRAC_BITS = 30;
	localparam int XY_BITS   = 34;
	localparam int Z_BITS    = 32;
	localparam int CS_BITS   = 32;
	localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = XY_BITS'(652032874);

	localparam logic signed [Z_BITS-1:0] ATAN_Q30 [32] = '{
		32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
		32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
		32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
		32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
		32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
		32'sd1023,      32'sd511,       32'sd255,       32'sd127,
		32'sd63,        32'sd31,        32'sd15,        32'sd7,
		32'sd3,         32'sd1,         32'sd0,         32'sd0
	};

	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} rpap_quad_t;

	typedef struct packed {
		logic       zero;
		rpap_quad_t quad;
	} rpap_ctl_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic signed [COORD_BITS-1:0] vx;
		logic signed [COORD_BITS-1:0] vy;
	} rpap_pts_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] rx;
		logic signed [COORD_BITS-1:0] ry;
		logic                         sat;
	} rpap_res_t;

endpackage

@@ hw/rtl/rpap_in_if.sv @@
// ----------------------------------------------------------------------------
// rpap_in_if: input channel of the point rotation block
// Valid/ready handshake carrying point, pivot and angle.
// ----------------------------------------------------------------------------
interface rpap_in_if import rpap_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] pivot_x;
	logic signed [COORD_BITS-1:0] pivot_y;
	logic signed [ANGLE_BITS-1:0] angle;

	modport source (output valid, point_x, point_y, pivot_x, pivot_y, angle, input ready);
	modport sink (input valid, point_x, point_y, pivot_x, pivot_y, angle, output ready);
endinterface

@@ hw/rtl/rpap_out_if.sv @@
// ----------------------------------------------------------------------------
// rpap_out_if: output channel of the point rotation block
// Valid/ready handshake carrying the rotated point and the clamp flag.
// ----------------------------------------------------------------------------
interface rpap_out_if import rpap_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] rotated_x;
	logic signed [COORD_BITS-1:0] rotated_y;
	logic                         saturated;

	modport source (output valid, rotated_x, rotated_y, saturated, input ready);
	modport sink (input valid, rotated_x, rotated_y, saturated, output ready);
endinterface

@@ hw/rtl/rpap_angle.sv @@
// ----------------------------------------------------------------------------
// rpap_angle: angle reduction and conversion to radians
// Five stages: modulo full turn, quadrant split, three-step fixed-point scale to
// Q2.30 radians.
// ----------------------------------------------------------------------------
module rpap_angle import rpap_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic signed [ANGLE_BITS-1:0] angle,
	input  rpap_pts_t                    in_pts,
	output logic                         out_valid,
	output logic signed [Z_BITS-1:0]     z,
	output rpap_ctl_t                    out_ctl,
	output rpap_pts_t                    out_pts
);

	localparam int T_BITS = $clog2((QUARTER_TURN - 1) * ZQ_INT + 1);
	localparam int M_BITS = $clog2((QUARTER_TURN - 1) * ZQ_FRAC + 1);
	localparam int V_BITS = M_BITS - ZQ_SHIFT;
	localparam int P_BITS = V_BITS + RECIP45_BITS;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [U_BITS-1:0] u, ubase;
	logic [R_BITS-1:0] r_s1;
	rpap_pts_t         pts_s1, pts_s2, pts_s3, pts_s4, pts_s5;

	logic [R_BITS-1:0]   qbase;
	rpap_quad_t          quad;
	logic [REM_BITS-1:0] rem_s2;
	rpap_ctl_t           ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	logic [T_BITS-1:0] t_s3, t_s4;
	logic [M_BITS-1:0] m_s3;
	logic [P_BITS-1:0] p_s4;

	logic signed [Z_BITS-1:0] z_s5;

	// Stage 1: bias into positive range, then strip whole turns
	always_comb begin
		u     = U_BITS'(angle) + U_BITS'(TURN_BIAS * FULL_TURN);
		ubase = '0;
		for (int k = 1; k <= MAX_TURNS; k++) begin
			if (u >= U_BITS'(k * FULL_TURN)) begin
				ubase = U_BITS'(k * FULL_TURN);
			end
		end
	end

	// Stage 2: quadrant and remainder within the quadrant
	always_comb begin
		if (r_s1 >= R_BITS'(3 * QUARTER_TURN)) begin
			quad  = QUAD_270;
			qbase = R_BITS'(3 * QUARTER_TURN);
		end else if (r_s1 >= R_BITS'(2 * QUARTER_TURN)) begin
			quad  = QUAD_180;
			qbase = R_BITS'(2 * QUARTER_TURN);
		end else if (r_s1 >= R_BITS'(QUARTER_TURN)) begin
			quad  = QUAD_90;
			qbase = R_BITS'(QUARTER_TURN);
		end else begin
			quad  = QUAD_0;
			qbase = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1        <= R_BITS'(u - ubase);
			pts_s1      <= in_pts;
			rem_s2      <= REM_BITS'(r_s1 - qbase);
			ctl_s2.zero <= (r_s1 == '0);
			ctl_s2.quad <= quad;
			pts_s2      <= pts_s1;
			// Stage 3: integer and fractional parts of the radian scale
			t_s3        <= T_BITS'(rem_s2) * T_BITS'(ZQ_INT);
			m_s3        <= M_BITS'(rem_s2) * M_BITS'(ZQ_FRAC);
			ctl_s3      <= ctl_s2;
			pts_s3      <= pts_s2;
			// Stage 4: divide by 45 through the reciprocal
			p_s4        <= P_BITS'(m_s3[M_BITS-1:ZQ_SHIFT]) * P_BITS'(RECIP45);
			t_s4        <= t_s3;
			ctl_s4      <= ctl_s3;
			pts_s4      <= pts_s3;
			// Stage 5: combine
			z_s5        <= signed'(Z_BITS'(t_s4) + Z_BITS'(p_s4[P_BITS-1:RECIP_SHIFT]));
			ctl_s5      <= ctl_s4;
			pts_s5      <= pts_s4;
		end
	end

	assign out_valid = v_s5;
	assign z         = z_s5;
	assign out_ctl   = ctl_s5;
	assign out_pts   = pts_s5;

	a_turn_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_valid) |=> (v_s1 && (r_s1 < R_BITS'(FULL_TURN))))
		else $error("angle not reduced below a full turn");

	a_quad_split: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1) |=> (v_s2 && (rem_s2 < REM_BITS'(QUARTER_TURN))
		&& (ctl_s2.zero == ($past(r_s1) == '0))))
		else $error("quadrant split out of range");

endmodule

@@ hw/rtl/rpap_cordic.sv @@
// ----------------------------------------------------------------------------
// rpap_cordic: unrolled gain-compensated CORDIC in rotation mode
// One register stage per step; yields cos and sin of z in Q1.30.
// ----------------------------------------------------------------------------
module rpap_cordic import rpap_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic signed [Z_BITS-1:0]  z,
	input  rpap_ctl_t                 in_ctl,
	input  rpap_pts_t                 in_pts,
	output logic                      out_valid,
	output logic signed [XY_BITS-1:0] cos_q,
	output logic signed [XY_BITS-1:0] sin_q,
	output rpap_ctl_t                 out_ctl,
	output rpap_pts_t                 out_pts
);

	logic                      v_s   [CORDIC_STEPS];
	logic signed [XY_BITS-1:0] x_s   [CORDIC_STEPS];
	logic signed [XY_BITS-1:0] y_s   [CORDIC_STEPS];
	logic signed [Z_BITS-1:0]  z_s   [CORDIC_STEPS];
	rpap_ctl_t                 ctl_s [CORDIC_STEPS];
	rpap_pts_t                 pts_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic                      vi;
		logic signed [XY_BITS-1:0] xi, yi, xn, yn;
		logic signed [Z_BITS-1:0]  zi, zn;
		rpap_ctl_t                 ci;
		rpap_pts_t                 pi;

		if (i == 0) begin : g_first
			assign vi = in_valid;
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = z;
			assign ci = in_ctl;
			assign pi = in_pts;
		end else begin : g_next
			assign vi = v_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ci = ctl_s[i-1];
			assign pi = pts_s[i-1];
		end

		// Rotate toward zero residual angle
		always_comb begin
			if (!zi[Z_BITS-1]) begin
				xn = xi - (yi >>> i);
				yn = yi + (xi >>> i);
				zn = zi - ATAN_Q30[i];
			end else begin
				xn = xi + (yi >>> i);
				yn = yi - (xi >>> i);
				zn = zi + ATAN_Q30[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (adv) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[i]   <= xn;
				y_s[i]   <= yn;
				z_s[i]   <= zn;
				ctl_s[i] <= ci;
				pts_s[i] <= pi;
			end
		end
	end

	assign out_valid = v_s[CORDIC_STEPS-1];
	assign cos_q     = x_s[CORDIC_STEPS-1];
	assign sin_q     = y_s[CORDIC_STEPS-1];
	assign out_ctl   = ctl_s[CORDIC_STEPS-1];
	assign out_pts   = pts_s[CORDIC_STEPS-1];

endmodule

@@ hw/rtl/rpap_xform.sv @@
// ----------------------------------------------------------------------------
// rpap_xform: quadrant fold, rotation products and pivot restore
// Five stages: select c/s, multiply, sum, truncate toward zero, add pivot and
// clamp.
// ----------------------------------------------------------------------------
module rpap_xform import rpap_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic signed [XY_BITS-1:0] cos_q,
	input  logic signed [XY_BITS-1:0] sin_q,
	input  rpap_ctl_t                 in_ctl,
	input  rpap_pts_t                 in_pts,
	output logic                      out_valid,
	output rpap_res_t                 res
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = CS_BITS + DW;
	localparam int SW = PW + 1;
	localparam int TW = SW - FRAC_BITS;
	localparam int RW = TW + 1;

	localparam logic signed [SW-1:0] TRUNC_BIAS = {{(SW - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
	localparam logic signed [RW-1:0] C_HI = RW'({1'b0, {(COORD_BITS - 1){1'b1}}});
	localparam logic signed [RW-1:0] C_LO = ~C_HI;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [XY_BITS-1:0] cw, sw;
	logic signed [CS_BITS-1:0] c_s1, s_s1;
	logic signed [DW-1:0]      dx_s1, dy_s1;
	logic signed [PW-1:0]      cdx_s2, sdy_s2, cdy_s2, sdx_s2;
	logic signed [SW-1:0]      sx_s3, sy_s3;
	logic signed [SW-1:0]      bx, by, tsx, tsy;
	logic signed [TW-1:0]      tx_s4, ty_s4;
	logic signed [RW-1:0]      rx, ry;
	logic                      zero_s1, zero_s2, zero_s3, zero_s4;
	rpap_pts_t                 pts_s1, pts_s2, pts_s3, pts_s4;
	rpap_res_t                 res_n, res_s5;

	// Fold quadrant into c and s
	always_comb begin
		case (in_ctl.quad)
			QUAD_0: begin
				cw = cos_q;
				sw = sin_q;
			end
			QUAD_90: begin
				cw = -sin_q;
				sw = cos_q;
			end
			QUAD_180: begin
				cw = -cos_q;
				sw = -sin_q;
			end
			QUAD_270: begin
				cw = sin_q;
				sw = -cos_q;
			end
			default: begin
				cw = cos_q;
				sw = sin_q;
			end
		endcase
	end

	// Truncate toward zero: bias negative sums before dropping fraction bits
	always_comb begin
		bx  = sx_s3[SW-1] ? TRUNC_BIAS : '0;
		by  = sy_s3[SW-1] ? TRUNC_BIAS : '0;
		tsx = sx_s3 + bx;
		tsy = sy_s3 + by;
	end

	// Restore pivot and clamp
	always_comb begin
		rx        = RW'(tx_s4) + RW'(pts_s4.vx);
		ry        = RW'(ty_s4) + RW'(pts_s4.vy);
		res_n.sat = 1'b0;
		if (rx > C_HI) begin
			res_n.rx  = COORD_BITS'(C_HI);
			res_n.sat = 1'b1;
		end else if (rx < C_LO) begin
			res_n.rx  = COORD_BITS'(C_LO);
			res_n.sat = 1'b1;
		end else begin
			res_n.rx = COORD_BITS'(rx);
		end
		if (ry > C_HI) begin
			res_n.ry  = COORD_BITS'(C_HI);
			res_n.sat = 1'b1;
		end else if (ry < C_LO) begin
			res_n.ry  = COORD_BITS'(C_LO);
			res_n.sat = 1'b1;
		end else begin
			res_n.ry = COORD_BITS'(ry);
		end
		if (zero_s4) begin
			res_n.rx  = pts_s4.px;
			res_n.ry  = pts_s4.py;
			res_n.sat = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1    <= CS_BITS'(cw);
			s_s1    <= CS_BITS'(sw);
			dx_s1   <= DW'(in_pts.px) - DW'(in_pts.vx);
			dy_s1   <= DW'(in_pts.py) - DW'(in_pts.vy);
			zero_s1 <= in_ctl.zero;
			pts_s1  <= in_pts;
			cdx_s2  <= PW'(c_s1) * PW'(dx_s1);
			sdy_s2  <= PW'(s_s1) * PW'(dy_s1);
			cdy_s2  <= PW'(c_s1) * PW'(dy_s1);
			sdx_s2  <= PW'(s_s1) * PW'(dx_s1);
			zero_s2 <= zero_s1;
			pts_s2  <= pts_s1;
			sx_s3   <= SW'(cdx_s2) + SW'(sdy_s2);
			sy_s3   <= SW'(cdy_s2) - SW'(sdx_s2);
			zero_s3 <= zero_s2;
			pts_s3  <= pts_s2;
			tx_s4   <= tsx[SW-1:FRAC_BITS];
			ty_s4   <= tsy[SW-1:FRAC_BITS];
			zero_s4 <= zero_s3;
			pts_s4  <= pts_s3;
			res_s5  <= res_n;
		end
	end

	assign out_valid = v_s5;
	assign res       = res_s5;

	a_zero_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s4 && zero_s4) |=> (v_s5 && !res_s5.sat
		&& (res_s5.rx == $past(pts_s4.px)) && (res_s5.ry == $past(pts_s4.py))))
		else $error("zero angle did not pass the point through");

endmodule

@@ hw/rtl/rpap_obuf.sv @@
// ----------------------------------------------------------------------------
// rpap_obuf: two-entry output buffer
// Output register plus skid register; stalls the pipeline only when both hold
// an item.
// ----------------------------------------------------------------------------
module rpap_obuf import rpap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  rpap_res_t   din,
	output logic        adv,
	rpap_out_if.source  out_item
);

	logic [1:0] cnt_q;
	rpap_res_t  head_q, skid_q;
	logic       push, pop;

	assign adv  = (cnt_q != 2'd2);
	assign push = adv && in_valid;
	assign pop  = out_item.valid && out_item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
			head_q <= din;
		end else if (push && cnt_q == 2'd1) begin
			skid_q <= din;
		end else if (pop && cnt_q == 2'd2) begin
			head_q <= skid_q;
		end
	end

	assign out_item.valid     = (cnt_q != 2'd0);
	assign out_item.rotated_x = head_q.rx;
	assign out_item.rotated_y = head_q.ry;
	assign out_item.saturated = head_q.sat;

	a_no_fill_jump: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |=> (cnt_q != 2'd2))
		else $error("output buffer filled by two items in one cycle");

	a_no_drain_jump: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |=> (cnt_q != 2'd0 && cnt_q != 2'd3))
		else $error("output buffer drained by two items in one cycle");

endmodule

@@ hw/rtl/rotate_point_about_pivot.sv @@
// ----------------------------------------------------------------------------
// rotate_point_about_pivot: clockwise rotation of a point about a pivot
// Usage:
//   in_item carries point_x/point_y, pivot_x/pivot_y and angle (1/256 degree,
//   clockwise, any sign). out_item returns rotated_x/rotated_y, truncated
//   toward zero and clamped to the coordinate range, plus saturated.
//   Both channels use valid/ready; an item moves when both are high.
//   Every input item yields exactly one output item, in order.
// Pipeline: 41 register stages from in_item to out_item.valid, the first
//   loaded at the accepting edge: the 5 angle stages, one stage per CORDIC
//   step, the 5 transform stages and the output register.
// Throughput: one item per cycle unless stalled; every section is fully
//   pipelined.
// Stall: the output holds its item until taken; a skid register absorbs one
//   more, after which in_item.ready drops and the whole pipeline holds. The
//   registered ready never depends on out_item.ready in the same cycle.
// Reset: arst_n clears all valid bits and the buffer count; nothing is in
//   flight afterwards and in_item.ready is high.
// A zero reduced angle passes the point through unchanged with saturated low.
// ----------------------------------------------------------------------------
module rotate_point_about_pivot import rpap_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rpap_in_if.sink    in_item,
	rpap_out_if.source out_item
);

	logic adv;

	rpap_pts_t in_pts;

	logic                     ang_valid;
	logic signed [Z_BITS-1:0] ang_z;
	rpap_ctl_t                ang_ctl;
	rpap_pts_t                ang_pts;

	logic                      cor_valid;
	logic signed [XY_BITS-1:0] cor_cos, cor_sin;
	rpap_ctl_t                 cor_ctl;
	rpap_pts_t                 cor_pts;

	logic      xf_valid;
	rpap_res_t xf_res;

	// Gather the input payload; the whole pipeline advances together
	assign in_pts.px     = in_item.point_x;
	assign in_pts.py     = in_item.point_y;
	assign in_pts.vx     = in_item.pivot_x;
	assign in_pts.vy     = in_item.pivot_y;
	assign in_item.ready = adv;

	// Reduce angle modulo a full turn and scale to radians
	rpap_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_item.valid),
		.angle     (in_item.angle),
		.in_pts    (in_pts),
		.out_valid (ang_valid),
		.z         (ang_z),
		.out_ctl   (ang_ctl),
		.out_pts   (ang_pts)
	);

	// Cosine and sine of the in-quadrant angle
	rpap_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (ang_valid),
		.z         (ang_z),
		.in_ctl    (ang_ctl),
		.in_pts    (ang_pts),
		.out_valid (cor_valid),
		.cos_q     (cor_cos),
		.sin_q     (cor_sin),
		.out_ctl   (cor_ctl),
		.out_pts   (cor_pts)
	);

	// Rotate the offset, restore the pivot, clamp
	rpap_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (cor_valid),
		.cos_q     (cor_cos),
		.sin_q     (cor_sin),
		.in_ctl    (cor_ctl),
		.in_pts    (cor_pts),
		.out_valid (xf_valid),
		.res       (xf_res)
	);

	// Output register with skid; drives the pipeline advance
	rpap_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (xf_valid),
		.din      (xf_res),
		.adv      (adv),
		.out_item (out_item)
	);

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for rotate_point_about_pivot
// Drives point/pivot/angle items through the valid/ready input channel and
// checks every rotated point against a hand-typed result or a bit-exact
// fixed-point CORDIC model kept in this file. A directed table covers zero
// and full-turn angles, coordinate and angle extremes, quadrant edges and
// clamping. About 1500 random items follow, with random idling on both
// channels, one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb_top;
	import rpap_pkg::*;

	// Timing of the run
	localparam int LATENCY        = 5 + CORDIC_STEPS + 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_START = 300;
	localparam int HOLD_OFF_LEN   = 150;
	localparam int STEADY_FIRST   = 600;
	localparam int STEADY_LAST    = 900;
	localparam int DRAIN_AT       = 1000;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int IDLE_PERCENT   = 7;
	localparam int REPORT_CAP     = 50;

	// Fixed-point constants of the rotation math
	localparam longint PI_QUARTER_Q30 = 843314857;
	localparam longint EIGHTH_TURN    = 11520;
	localparam longint GAIN_Q30       = 652032874;
	localparam longint Q30_ONE        = longint'(1) << 30;
	localparam longint COORD_HI       = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint COORD_LO       = -COORD_HI - 1;

	// Arctangent of 2^-i in Q2.30 radians, truncated
	localparam longint ARCTAN_Q30 [32] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
		127, 63, 31, 15, 7, 3, 1, 0, 0
	};

	localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [ANGLE_BITS-1:0] A_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};
	localparam logic signed [ANGLE_BITS-1:0] A_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	// One row of the directed table; known marks a result typed in by hand
	typedef struct {
		rpap_pts_t                    pts;
		logic signed [ANGLE_BITS-1:0] angle;
		bit                           known;
		rpap_res_t                    res;
	} directed_row_t;

	localparam int N_DIRECTED = 21;

	directed_row_t directed_rows [N_DIRECTED] = '{
		// zero reduced angle: point passes through unchanged
		'{'{24'sd100, -24'sd200, 24'sd5, 24'sd7}, 20'sd0, 1'b1,
			'{24'sd100, -24'sd200, 1'b0}},
		'{'{C_MAX, C_MIN, 24'sd0, 24'sd0}, 20'sd92160, 1'b1, '{C_MAX, C_MIN, 1'b0}},
		'{'{C_MIN, C_MAX, C_MAX, C_MIN}, -20'sd92160, 1'b1, '{C_MIN, C_MAX, 1'b0}},
		'{'{-24'sd1, 24'sd1, 24'sd12345, -24'sd54321}, 20'sd460800, 1'b1,
			'{-24'sd1, 24'sd1, 1'b0}},
		'{'{24'sd0, 24'sd0, 24'sd0, 24'sd0}, -20'sd460800, 1'b1,
			'{24'sd0, 24'sd0, 1'b0}},
		// point on the pivot stays on the pivot at any angle
		'{'{24'sd1234, -24'sd5678, 24'sd1234, -24'sd5678}, 20'sd1000, 1'b1,
			'{24'sd1234, -24'sd5678, 1'b0}},
		// half turn from corner to corner clamps both coordinates low
		'{'{C_MAX, C_MAX, C_MIN, C_MIN}, 20'sd46080, 1'b1, '{C_MIN, C_MIN, 1'b1}},
		'{'{C_MAX, C_MAX, C_MIN, C_MIN}, -20'sd46080, 1'b1, '{C_MIN, C_MIN, 1'b1}},
		// one angle in each quadrant
		'{'{C_MAX, C_MAX, C_MIN, C_MIN}, 20'sd11520, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		'{'{24'sd1000, -24'sd300, 24'sd0, 24'sd0}, 20'sd34560, 1'b0,
			'{24'sd0, 24'sd0, 1'b0}},
		'{'{-24'sd7000, 24'sd3000, 24'sd10, -24'sd10}, 20'sd57600, 1'b0,
			'{24'sd0, 24'sd0, 1'b0}},
		'{'{C_MIN, C_MIN, C_MAX, C_MAX}, 20'sd80640, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		// quadrant edges
		'{'{24'sd1000, 24'sd0, 24'sd0, 24'sd0}, 20'sd23040, 1'b0,
			'{24'sd0, 24'sd0, 1'b0}},
		'{'{24'sd500, 24'sd500, 24'sd0, 24'sd0}, 20'sd69120, 1'b0,
			'{24'sd0, 24'sd0, 1'b0}},
		'{'{24'sd8000, -24'sd8000, 24'sd0, 24'sd0}, 20'sd23039, 1'b0,
			'{24'sd0, 24'sd0, 1'b0}},
		'{'{24'sd8000, -24'sd8000, 24'sd0, 24'sd0}, 20'sd92159, 1'b0,
			'{24'sd0, 24'sd0, 1'b0}},
		// smallest steps either way: negative angles wrap to clockwise ones
		'{'{24'sd123456, -24'sd654321, -24'sd1, 24'sd1}, 20'sd1, 1'b0,
			'{24'sd0, 24'sd0, 1'b0}},
		'{'{24'sd123456, -24'sd654321, -24'sd1, 24'sd1}, -20'sd1, 1'b0,
			'{24'sd0, 24'sd0, 1'b0}},
		// angle code extremes, then opposite coordinate corners at an eighth turn
		'{'{C_MAX, 24'sd0, 24'sd0, 24'sd0}, A_MAX, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		'{'{24'sd0, C_MIN, C_MAX, 24'sd0}, A_MIN, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
		'{'{C_MAX, C_MIN, C_MIN, C_MAX}, 20'sd11520, 1'b0, '{24'sd0, 24'sd0, 1'b0}}
	};

	logic clk;
	logic arst_n;

	rpap_in_if  in_ch ();
	rpap_out_if out_ch ();

	rotate_point_about_pivot DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_ch),
		.out_item (out_ch)
	);

	// Rotated points still owed by the block, oldest first
	rpap_res_t   pending_rotations [$];
	int unsigned items_accepted;
	int unsigned results_seen;
	int unsigned mismatch_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP) begin
			$display("MISMATCH result %0d: %s", results_seen, what);
		end
	endtask

	// Both channels run without idling through this window of items
	function automatic bit in_steady_stretch();
		return items_accepted >= STEADY_FIRST && items_accepted < STEADY_LAST;
	endfunction

	// Rotate one point clockwise about its pivot, exactly as the hardware does:
	// reduce the angle, run the CORDIC on the remainder within the quadrant,
	// fold in the quadrant, transform, truncate toward zero, add pivot, clamp.
	function automatic rpap_res_t predict_rotation(input rpap_pts_t pts,
		input logic signed [ANGLE_BITS-1:0] ang);
		longint px, py, vx, vy, dx, dy;
		longint red, rem, z, x, y, xs, ys, c, s, rx, ry;
		rpap_quad_t quad;
		rpap_res_t  res;

		px = pts.px;
		py = pts.py;
		vx = pts.vx;
		vy = pts.vy;
		res.sat = 1'b0;

		red = longint'(ang) % FULL_TURN;
		if (red < 0) begin
			red = red + FULL_TURN;
		end
		if (red == 0) begin
			res.rx = pts.px;
			res.ry = pts.py;
			return res;
		end

		quad = rpap_quad_t'(red / QUARTER_TURN);
		rem  = red % QUARTER_TURN;
		z    = rem * PI_QUARTER_Q30 / EIGHTH_TURN;

		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			// arithmetic shifts round toward minus infinity
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN_Q30[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN_Q30[i];
			end
		end

		case (quad)
			QUAD_0: begin
				c = x;
				s = y;
			end
			QUAD_90: begin
				c = -y;
				s = x;
			end
			QUAD_180: begin
				c = -x;
				s = -y;
			end
			default: begin
				c = y;
				s = -x;
			end
		endcase

		dx = px - vx;
		dy = py - vy;
		// integer divide truncates toward zero
		rx = (c * dx + s * dy) / Q30_ONE + vx;
		ry = (c * dy - s * dx) / Q30_ONE + vy;

		if (rx > COORD_HI) begin
			rx = COORD_HI;
			res.sat = 1'b1;
		end else if (rx < COORD_LO) begin
			rx = COORD_LO;
			res.sat = 1'b1;
		end
		if (ry > COORD_HI) begin
			ry = COORD_HI;
			res.sat = 1'b1;
		end else if (ry < COORD_LO) begin
			ry = COORD_LO;
			res.sat = 1'b1;
		end
		res.rx = COORD_BITS'(rx);
		res.ry = COORD_BITS'(ry);
		return res;
	endfunction

	// Offer one item from the falling edge, idling now and then, and hold it
	// until the block takes it. The expected rotation is queued on acceptance.
	task automatic send_item(input rpap_pts_t pts, input logic signed [ANGLE_BITS-1:0] ang,
		input bit known, input rpap_res_t known_res);
		rpap_res_t owed;

		@(negedge clk);
		while (!in_steady_stretch() && $urandom_range(99) < IDLE_PERCENT) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.point_x = pts.px;
		in_ch.point_y = pts.py;
		in_ch.pivot_x = pts.vx;
		in_ch.pivot_y = pts.vy;
		in_ch.angle   = ang;
		in_ch.valid   = 1'b1;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		owed = known ? known_res : predict_rotation(pts, ang);
		pending_rotations = {pending_rotations, owed};
		items_accepted++;
	endtask

	// Coordinate classes: full 24-bit range, near the origin, or the extremes
	function automatic logic signed [COORD_BITS-1:0] pick_coord(input int cls);
		case (cls)
			0: return COORD_BITS'($urandom);
			1: return COORD_BITS'(int'($urandom_range(4000)) - 2000);
			default: begin
				case ($urandom_range(3))
					0: return C_MAX;
					1: return C_MIN;
					2: return '0;
					default: return COORD_BITS'($urandom);
				endcase
			end
		endcase
	endfunction

	// Angle classes: whole turns (pass-through), near a quadrant edge, or any
	function automatic logic signed [ANGLE_BITS-1:0] pick_angle();
		int roll;
		int turns;
		int edge_at;

		roll = $urandom_range(99);
		if (roll < 12) begin
			turns = int'($urandom_range(10)) - 5;
			return ANGLE_BITS'(turns * FULL_TURN);
		end
		if (roll < 35) begin
			turns   = int'($urandom_range(6)) - 3;
			edge_at = int'($urandom_range(3)) * QUARTER_TURN;
			return ANGLE_BITS'(turns * FULL_TURN + edge_at + int'($urandom_range(4)) - 2);
		end
		return ANGLE_BITS'($urandom);
	endfunction

	// Output side: take items at random, hold off once for a long stretch so
	// that the pipeline fills and the input stalls.
	initial begin
		bit hold_off_done;

		hold_off_done = 1'b0;
		out_ch.ready  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!hold_off_done && items_accepted >= HOLD_OFF_START) begin
				out_ch.ready = 1'b0;
				repeat (HOLD_OFF_LEN) @(negedge clk);
				hold_off_done = 1'b1;
			end
			out_ch.ready = in_steady_stretch() || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Compare each delivered rotation with the oldest one owed
	always @(posedge clk) begin
		rpap_res_t want;

		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_rotations.size() == 0) begin
				report_mismatch($sformatf("unexpected item x=%0d y=%0d sat=%0b",
					out_ch.rotated_x, out_ch.rotated_y, out_ch.saturated));
			end else begin
				want = pending_rotations.pop_front();
				if (out_ch.rotated_x !== want.rx) begin
					report_mismatch($sformatf("rotated_x got %0d expected %0d",
						out_ch.rotated_x, want.rx));
				end
				if (out_ch.rotated_y !== want.ry) begin
					report_mismatch($sformatf("rotated_y got %0d expected %0d",
						out_ch.rotated_y, want.ry));
				end
				if (out_ch.saturated !== want.sat) begin
					report_mismatch($sformatf("saturated got %0b expected %0b",
						out_ch.saturated, want.sat));
				end
			end
			results_seen++;
		end
	end

	// Stop a hung run: too many cycles in a row with no item moving either way
	initial begin
		int unsigned quiet_cycles;

		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("** rotate_point_about_pivot: FAILED **");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		rpap_pts_t pts;
		rpap_res_t no_res;
		int        cls;

		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.point_x  = '0;
		in_ch.point_y  = '0;
		in_ch.pivot_x  = '0;
		in_ch.pivot_y  = '0;
		in_ch.angle    = '0;
		items_accepted = 0;
		results_seen   = 0;
		mismatch_count = 0;
		no_res         = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].pts, directed_rows[i].angle,
				directed_rows[i].known, directed_rows[i].res);
		end

		// Random items; all four coordinates share one class per item
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == DRAIN_AT) begin
				// drop valid and let everything owed come out first
				@(negedge clk);
				in_ch.valid = 1'b0;
				while (pending_rotations.size() != 0) @(posedge clk);
			end
			cls    = $urandom_range(2);
			pts.px = pick_coord(cls);
			pts.py = pick_coord(cls);
			pts.vx = pick_coord(cls);
			pts.vy = pick_coord(cls);
			send_item(pts, pick_angle(), 1'b0, no_res);
		end

		@(negedge clk);
		in_ch.valid = 1'b0;

		// Drain, then leave room for anything extra to show up
		while (pending_rotations.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);

		if (pending_rotations.size() != 0) begin
			report_mismatch($sformatf("%0d rotations never delivered",
				pending_rotations.size()));
		end
		if (mismatch_count == 0) begin
			$display("** rotate_point_about_pivot: PASSED **");
		end else begin
			$display("** rotate_point_about_pivot: FAILED **");
		end
		$finish;
	end

endmodule
